### rtl/two_walker_grid_max_collect_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-walker grid max-collect unit
// Implication checks on the rising edge, with a reset guard via disable iff.
// ----------------------------------------------------------------------------
`ifndef TWO_WALKER_GRID_MAX_COLLECT_UNIT_ASSERT_SVH
`define TWO_WALKER_GRID_MAX_COLLECT_UNIT_ASSERT_SVH

// same-cycle implication
`define TWGMC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TWGMC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/twgmc_pkg.sv
// ----------------------------------------------------------------------------
// twgmc_pkg
// Shared sizes, codes and request structs of the grid max-collect unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package twgmc_pkg;

  localparam int ROWS_MAX   = 64;
  localparam int COLS_MAX   = 64;
  localparam int VALUE_BITS = 16;
  localparam int TOTAL_W    = 23;
  localparam int CNT_W      = 7;
  localparam int GAIN_W     = VALUE_BITS + 1;
  localparam int COL_IDX_W  = ($clog2(COLS_MAX) > 0) ? $clog2(COLS_MAX) : 1;
  localparam int ROW_IDX_W  = ($clog2(ROWS_MAX) > 0) ? $clog2(ROWS_MAX) : 1;
  localparam int OFF_W      = COL_IDX_W + 2;
  localparam int SR_ADDR_W  = 1 + 2 * COL_IDX_W;
  localparam int CFG_IDX_W  = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

  // column step selectors: predecessor = current - step
  localparam logic [1:0] STEP_MINUS = 2'd0;
  localparam logic [1:0] STEP_ZERO  = 2'd1;
  localparam logic [1:0] STEP_PLUS  = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PAIR,
    ST_CAND,
    ST_FOLD,
    ST_WRITE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                  we;
    logic [COL_IDX_W-1:0]  waddr;
    logic [VALUE_BITS-1:0] wdata;
    logic [COL_IDX_W-1:0]  raddr_a;
    logic [COL_IDX_W-1:0]  raddr_b;
  } rb_req_t;

  typedef struct packed {
    logic                 we;
    logic                 wbank;
    logic [COL_IDX_W-1:0] wl;
    logic [COL_IDX_W-1:0] wr;
    logic [TOTAL_W-1:0]   wdata;
    logic [SR_ADDR_W-1:0] raddr;
  } sr_req_t;

endpackage

`default_nettype wire

### rtl/twgmc_row_buf.sv
// ----------------------------------------------------------------------------
// twgmc_row_buf
// Current-row cell buffer: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module twgmc_row_buf (
  input  wire logic                            clk,
  input  wire twgmc_pkg::rb_req_t              req,
  output logic [twgmc_pkg::VALUE_BITS-1:0]     rdata_a,
  output logic [twgmc_pkg::VALUE_BITS-1:0]     rdata_b
);
  import twgmc_pkg::*;

  logic [VALUE_BITS-1:0] mem [COLS_MAX];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_a <= mem[req.raddr_a];
    rdata_b <= mem[req.raddr_b];
  end

endmodule

`default_nettype wire

### rtl/twgmc_score_ram.sv
// ----------------------------------------------------------------------------
// twgmc_score_ram
// Pair score table, two banks (previous / current row), 1W1R registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module twgmc_score_ram (
  input  wire logic                         clk,
  input  wire twgmc_pkg::sr_req_t           req,
  output logic [twgmc_pkg::TOTAL_W-1:0]     rdata
);
  import twgmc_pkg::*;

  localparam int DEPTH = 2 ** SR_ADDR_W;

  logic [TOTAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[{req.wbank, req.wl, req.wr}] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

### rtl/twgmc_seq.sv
// ----------------------------------------------------------------------------
// twgmc_seq
// Load counters and pair-sweep sequencer with its max and add logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module twgmc_seq (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [twgmc_pkg::CNT_W-1:0]      rows,
  input  wire logic [twgmc_pkg::CNT_W-1:0]      cols,
  input  wire logic                             cell_valid,
  input  wire logic [twgmc_pkg::VALUE_BITS-1:0] cell_value,
  output logic                                  ready,
  input  wire logic                             out_free,
  output logic                                  res_valid,
  output logic [twgmc_pkg::TOTAL_W-1:0]         res_total,
  output twgmc_pkg::rb_req_t                    rb_req,
  input  wire logic [twgmc_pkg::VALUE_BITS-1:0] rb_rdata_a,
  input  wire logic [twgmc_pkg::VALUE_BITS-1:0] rb_rdata_b,
  output twgmc_pkg::sr_req_t                    sr_req,
  input  wire logic [twgmc_pkg::TOTAL_W-1:0]    sr_rdata
);
  import twgmc_pkg::*;

  state_t                state, state_next;
  logic [COL_IDX_W-1:0]  col_idx;
  logic [ROW_IDX_W-1:0]  row_idx;
  logic                  bank;
  logic [COL_IDX_W-1:0]  l, r;
  logic [1:0]            dl_sel, dr_sel;
  logic                  rd_ok;
  logic [TOTAL_W-1:0]    best;
  logic [GAIN_W-1:0]     gain;
  logic [TOTAL_W-1:0]    run_max;

  logic                  last_col, last_row, r_end, pair_last, cand_last;
  logic [OFF_W-1:0]      pl1, pr1;    // predecessor column plus one
  logic                  cand_ok, same_ok;
  logic [TOTAL_W-1:0]    total;
  logic [COL_IDX_W-1:0]  pl, pr;

  assign last_col  = (CNT_W'(col_idx) + CNT_W'(1)) == cols;
  assign last_row  = (CNT_W'(row_idx) + CNT_W'(1)) == rows;
  assign r_end     = (CNT_W'(r) + CNT_W'(1)) == cols;
  assign pair_last = r_end && (CNT_W'(l) + CNT_W'(1)) == cols;
  assign cand_last = (dl_sel == STEP_PLUS) && (dr_sel == STEP_PLUS);

  assign pl1 = OFF_W'(l) + OFF_W'(2) - OFF_W'(dl_sel);
  assign pr1 = OFF_W'(r) + OFF_W'(2) - OFF_W'(dr_sel);
  assign pl  = COL_IDX_W'(pl1 - OFF_W'(1));
  assign pr  = COL_IDX_W'(pr1 - OFF_W'(1));

  // shared column: only left-steps-in, stay, right-steps-out
  assign same_ok = (dl_sel == STEP_MINUS && dr_sel == STEP_ZERO) ||
                   (dl_sel == STEP_ZERO  && dr_sel == STEP_ZERO) ||
                   (dl_sel == STEP_ZERO  && dr_sel == STEP_PLUS);
  assign cand_ok = (pl1 != '0) && (pr1 != '0) &&
                   (pl1 <= OFF_W'(cols)) && (pr1 <= OFF_W'(cols)) &&
                   (pl1 <= pr1) && ((pl1 != pr1) || same_ok);

  assign total = best + TOTAL_W'(gain);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:  if (cell_valid && !cfg_we && last_col) state_next = ST_PAIR;
      ST_PAIR:  state_next = (row_idx == '0) ? ST_FOLD : ST_CAND;
      ST_CAND:  if (cand_last) state_next = ST_FOLD;
      ST_FOLD:  state_next = ST_WRITE;
      ST_WRITE: begin
        if (pair_last) begin
          state_next = last_row ? ST_EMIT : ST_LOAD;
        end else begin
          state_next = ST_PAIR;
        end
      end
      ST_EMIT:  if (out_free) state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    ready          = (state == ST_LOAD);
    res_valid      = (state == ST_EMIT) && out_free;
    res_total      = run_max;
    rb_req.we      = (state == ST_LOAD) && cell_valid;
    rb_req.waddr   = col_idx;
    rb_req.wdata   = cell_value;
    rb_req.raddr_a = l;
    rb_req.raddr_b = r;
    sr_req.we      = (state == ST_WRITE);
    sr_req.wbank   = bank;
    sr_req.wl      = l;
    sr_req.wr      = r;
    sr_req.wdata   = total;
    sr_req.raddr   = {~bank, pl, pr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      col_idx <= '0;
      row_idx <= '0;
      bank    <= 1'b0;
      rd_ok   <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_LOAD: begin
          if (cfg_we) begin
            col_idx <= '0;
            row_idx <= '0;
          end else if (cell_valid) begin
            if (last_col) begin
              col_idx <= '0;
              l       <= '0;
              r       <= '0;
              run_max <= '0;
            end else begin
              col_idx <= col_idx + COL_IDX_W'(1);
            end
          end
        end
        ST_PAIR: begin
          dl_sel <= STEP_MINUS;
          dr_sel <= STEP_MINUS;
          best   <= '0;
          rd_ok  <= 1'b0;
        end
        ST_CAND: begin
          rd_ok <= cand_ok;
          if (rd_ok && sr_rdata > best) best <= sr_rdata;
          if (dr_sel == STEP_PLUS) begin
            dr_sel <= STEP_MINUS;
            dl_sel <= dl_sel + 2'd1;
          end else begin
            dr_sel <= dr_sel + 2'd1;
          end
        end
        ST_FOLD: begin
          rd_ok <= 1'b0;
          if (rd_ok && sr_rdata > best) best <= sr_rdata;
          gain  <= GAIN_W'(rb_rdata_a) + ((l != r) ? GAIN_W'(rb_rdata_b) : '0);
        end
        ST_WRITE: begin
          if (total > run_max) run_max <= total;
          if (pair_last) begin
            bank    <= ~bank;
            row_idx <= last_row ? '0 : row_idx + ROW_IDX_W'(1);
          end else if (r_end) begin
            l <= l + COL_IDX_W'(1);
            r <= l + COL_IDX_W'(1);
          end else begin
            r <= r + COL_IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/two_walker_grid_max_collect_unit.sv
// ----------------------------------------------------------------------------
// two_walker_grid_max_collect_unit
// Best two-walker collection total over a streamed grid, row-by-row sweep.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel sets row_count (index 0) and col_count (index 1); zero reads
//   as 1, values above 64 as 64. Any write restarts grid loading. Write only
//   while idle. cfg_ready is always high.
//   Slave stream: one cell per transaction, row-major. Cells inside a row
//   are accepted back to back. The cell ending a row starts a sweep over all pairs
//   l <= r, P = cols*(cols+1)/2 of them; s_tready is low during it.
//   Each pair goes through setup, candidate reads (later rows only: one
//   score-table read per candidate through a single read port, 9 per
//   pair), drain and write-back. Throughput is bounded by the row sweep.
//   Master stream: one transaction after the last cell of the last row,
//   passed on by the emit state after its sweep. The result sits in an output
//   register; if the receiver stalls, the next grid still loads and sweeps,
//   and only the hand-off after its final sweep waits for the register to
//   empty (s_tready stays low meanwhile).
//   Reset: counts go to 1, load position to zero, output empties. Score
//   storage is not cleared; each row writes every pair before it is read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module two_walker_grid_max_collect_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [twgmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [twgmc_pkg::CNT_W-1:0]       cfg_data,
  // cell stream in
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [15:0]                       s_tdata,  // [15:0] cell_value
  // result stream out
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [23:0]                            m_tdata   // [22:0] best_total
);
  import twgmc_pkg::*;

  `include "two_walker_grid_max_collect_unit_assert.svh"

  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v,
                                                 input int unsigned maxv);
    logic [CNT_W-1:0] res;
    if (v == '0) begin
      res = CNT_W'(1);
    end else if (int'(v) > maxv) begin
      res = CNT_W'(maxv);
    end else begin
      res = v;
    end
    return res;
  endfunction

  logic [CNT_W-1:0]      row_count, col_count;   // held already clamped
  logic                  cfg_we;
  logic                  out_valid;
  logic [TOTAL_W-1:0]    out_data;

  logic                  res_valid;
  logic [TOTAL_W-1:0]    res_total;
  rb_req_t               rb_req;
  sr_req_t               sr_req;
  logic [VALUE_BITS-1:0] rb_rdata_a, rb_rdata_b;
  logic [TOTAL_W-1:0]    sr_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= CNT_W'(1);
      col_count <= CNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_COUNT: row_count <= clamp_cnt(cfg_data, ROWS_MAX);
        REG_COL_COUNT: col_count <= clamp_cnt(cfg_data, COLS_MAX);
        default: ;
      endcase
    end
  end

  // output register: one pending result; the sequencer's hand-off waits while it is full
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_data <= res_total;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_data};

  twgmc_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .rows       (row_count),
    .cols       (col_count),
    .cell_valid (s_tvalid),
    .cell_value (s_tdata[VALUE_BITS-1:0]),
    .ready      (s_tready),
    .out_free   (!out_valid),
    .res_valid  (res_valid),
    .res_total  (res_total),
    .rb_req     (rb_req),
    .rb_rdata_a (rb_rdata_a),
    .rb_rdata_b (rb_rdata_b),
    .sr_req     (sr_req),
    .sr_rdata   (sr_rdata)
  );

  twgmc_row_buf u_row_buf (
    .clk     (clk),
    .req     (rb_req),
    .rdata_a (rb_rdata_a),
    .rdata_b (rb_rdata_b)
  );

  twgmc_score_ram u_score_ram (
    .clk   (clk),
    .req   (sr_req),
    .rdata (sr_rdata)
  );

  // a result never overwrites one still waiting
  `TWGMC_ASSERT_IMP(a_no_overwrite, clk, rst, res_valid, !out_valid, "result overwrite")
  // table entries exist only for l <= r
  `TWGMC_ASSERT_IMP(a_pair_order, clk, rst, sr_req.we, sr_req.wl <= sr_req.wr, "pair l > r")
  // row buffer is written only by an accepted cell
  `TWGMC_ASSERT_IMP(a_rb_write, clk, rst, rb_req.we, s_tvalid && s_tready, "stray row write")
  // after handing off a result the block is ready for the next grid
  `TWGMC_ASSERT_NXT(a_back_to_load, clk, rst, res_valid, s_tready, "not ready after result")

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-walker grid max-collect unit. Cells are
// streamed in row-major order. A local copy of the pair table predicts the
// best total of each grid. Each result transaction is compared with the
// oldest prediction. Directed grids come first, then random grids under
// three idle mixes.
// ----------------------------------------------------------------------------
module tb;
  import twgmc_pkg::*;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT hookup. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CNT_W-1:0]      cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata   = '0;  // [15:0] cell_value
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [23:0]           m_tdata;         // [22:0] best_total

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  two_walker_grid_max_collect_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // --------------------------------------------------------------------------
  // Run state
  // --------------------------------------------------------------------------
  typedef enum {FILL_TINY, FILL_MAX, FILL_EDGES, FILL_ANY} fill_t;

  int unsigned send_idle_pct = 37;  // chance that the sender holds off a cycle
  int unsigned recv_idle_pct = 64;  // chance that the receiver drops tready
  int unsigned fail_count    = 0;
  int unsigned cells_sent    = 0;
  int unsigned totals_seen   = 0;
  int unsigned cfg_writes    = 0;
  int unsigned broken_grids  = 0;

  // predicted best totals, oldest first
  logic [TOTAL_W-1:0] expected_totals [$];
  logic [TOTAL_W-1:0] head_total;

  // --------------------------------------------------------------------------
  // Grid predictor: raw register copies, load position, current row and the
  // best total for every walker pair (l <= r) after the last finished row.
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]      grid_rows_reg = 7'd1;
  logic [CNT_W-1:0]      grid_cols_reg = 7'd1;
  int unsigned           load_row = 0;
  int unsigned           load_col = 0;
  logic [VALUE_BITS-1:0] row_cells  [COLS_MAX];
  logic [TOTAL_W-1:0]    pair_best  [COLS_MAX][COLS_MAX];
  logic [TOTAL_W-1:0]    pair_fresh [COLS_MAX][COLS_MAX];

  // zero counts as one, anything above the limit as the limit
  function automatic int unsigned used_count(logic [CNT_W-1:0] raw, int unsigned limit);
    if (raw == '0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  // Best earlier total among the pairs that may step to (l, r). From a shared
  // column the walkers may only go to (p-1,p), (p,p) or (p,p+1).
  function automatic logic [TOTAL_W-1:0] best_source(int l, int r, int cols);
    logic [TOTAL_W-1:0] best;
    int pl, pr;
    best = '0;
    for (int dl = -1; dl <= 1; dl++) begin
      for (int dr = -1; dr <= 1; dr++) begin
        pl = l - dl;
        pr = r - dr;
        if (pl < 0 || pr < 0 || pl >= cols || pr >= cols || pl > pr) continue;
        if (pl == pr && !((dl == -1 && dr == 0) || (dl == 0 && dr == 0) ||
                          (dl == 0 && dr == 1))) continue;
        if (pair_best[pl][pr] > best) best = pair_best[pl][pr];
      end
    end
    return best;
  endfunction

  // fold one completed row into the pair table
  function automatic void fold_row(int cols);
    logic [TOTAL_W-1:0] gain;
    for (int l = 0; l < cols; l++) begin
      for (int r = l; r < cols; r++) begin
        gain = row_cells[l] + ((l != r) ? row_cells[r] : '0);
        pair_fresh[l][r] = ((load_row == 0) ? '0 : best_source(l, r, cols)) + gain;
      end
    end
    for (int l = 0; l < cols; l++)
      for (int r = l; r < cols; r++) pair_best[l][r] = pair_fresh[l][r];
  endfunction

  // take one cell; flags a total when it closes the grid
  function automatic void predict_cell(input logic [VALUE_BITS-1:0] value,
                                       output bit grid_done,
                                       output logic [TOTAL_W-1:0] total);
    int unsigned rows, cols;
    rows = used_count(grid_rows_reg, ROWS_MAX);
    cols = used_count(grid_cols_reg, COLS_MAX);
    grid_done = 1'b0;
    total = '0;
    if (load_col >= cols) load_col = 0;
    if (load_row >= rows) load_row = 0;
    row_cells[load_col] = value;
    load_col++;
    if (load_col < cols) return;
    load_col = 0;
    fold_row(cols);
    load_row++;
    if (load_row < rows) return;
    load_row = 0;
    for (int l = 0; l < cols; l++)
      for (int r = l; r < cols; r++)
        if (pair_best[l][r] > total) total = pair_best[l][r];
    grid_done = 1'b1;
  endfunction

  // row sweep length at the current width, with margin
  function automatic int unsigned sweep_cycles();
    int unsigned c;
    c = used_count(grid_cols_reg, COLS_MAX);
    return 12 * c * (c + 1) / 2 + 64;
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value(fill_t fill);
    case (fill)
      FILL_TINY:  return VALUE_BITS'($urandom_range(3));
      FILL_MAX:   return '1;
      FILL_EDGES: return $urandom_range(1) ? '1 : '0;
      default:    return VALUE_BITS'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic void note_failure(string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] MISMATCH %s", $time, what);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random tready, and a check of every result transaction
  // against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_totals.size() == 0) begin
        note_failure($sformatf("result %0d with nothing expected",
                               m_tdata[TOTAL_W-1:0]));
      end else begin
        head_total = expected_totals.pop_front();
        totals_seen++;
        if (m_tdata[TOTAL_W-1:0] !== head_total)
          note_failure($sformatf("best_total expected %0d got %0d",
                                 head_total, m_tdata[TOTAL_W-1:0]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared driving tasks
  // --------------------------------------------------------------------------

  // One cell transaction. tvalid stays high after acceptance; the next task
  // either lowers it or presents new data at the following falling edge.
  task automatic send_cell(input logic [VALUE_BITS-1:0] value);
    bit                 grid_done;
    logic [TOTAL_W-1:0] total;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    predict_cell(value, grid_done, total);
    if (grid_done) expected_totals = {expected_totals, total};
    cells_sent++;
  endtask

  // Stop sending and wait until every predicted total has arrived. A grid
  // left partway may still be sweeping, so give that sweep time to finish.
  task automatic await_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_totals.size() != 0) @(posedge clk);
    if (load_row != 0 || load_col != 0) repeat (sweep_cycles()) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CNT_W-1:0] value);
    await_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ROW_COUNT) grid_rows_reg = value;
    else grid_cols_reg = value;
    // any write restarts loading
    load_row = 0;
    load_col = 0;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // reset leaves a 1x1 grid: each cell is its own total
  task automatic test_single_cells();
    send_cell('0);
    send_cell('1);
    send_cell(16'd1234);
  endtask

  // one column, zero written as the width: both walkers share every cell
  task automatic test_single_column();
    write_register(REG_ROW_COUNT, 7'd3);
    write_register(REG_COL_COUNT, 7'd0);
    send_cell('1);
    send_cell('1);
    send_cell(16'd7);
  endtask

  // 3x3 grid where meeting and splitting the walkers matters
  task automatic test_shared_moves();
    logic [VALUE_BITS-1:0] cells [9];
    cells = '{16'd7, 16'd0, 16'd3,
              16'd0, 16'd8, 16'd0,
              16'd4, 16'd0, 16'd4};
    write_register(REG_ROW_COUNT, 7'd3);
    write_register(REG_COL_COUNT, 7'd3);
    foreach (cells[i]) send_cell(cells[i]);
  endtask

  // a write partway through a grid throws away what was loaded
  task automatic test_restart_midgrid();
    write_register(REG_ROW_COUNT, 7'd2);
    for (int i = 0; i < 4; i++) send_cell(pick_value(FILL_ANY));
    write_register(REG_COL_COUNT, 7'd2);
    for (int i = 0; i < 4; i++) send_cell(pick_value(FILL_ANY));
  endtask

  // Largest sizes and the largest total: 127 rows clamp to 64 and an all-max
  // two-column grid comes close to the top of the output range; 127 columns clamp
  // to 64; a full-width grid runs a second-row sweep over every pair.
  task automatic test_size_limits();
    write_register(REG_ROW_COUNT, 7'd127);
    write_register(REG_COL_COUNT, 7'd2);
    for (int i = 0; i < 128; i++) send_cell('1);
    write_register(REG_ROW_COUNT, 7'd0);
    write_register(REG_COL_COUNT, 7'd127);
    for (int i = 0; i < 64; i++) send_cell(pick_value(FILL_ANY));
    write_register(REG_ROW_COUNT, 7'd2);
    write_register(REG_COL_COUNT, 7'd64);
    for (int i = 0; i < 128; i++) send_cell(pick_value(FILL_ANY));
  endtask

  // Mostly complete small grids with random content; a few grids are cut
  // short and followed by a restart.
  task automatic test_random_grids(input int unsigned budget);
    int unsigned      first, rows, cols, cells, shape;
    logic [CNT_W-1:0] rows_raw, cols_raw;
    bit               restart_needed;
    fill_t            fill;
    first = cells_sent;
    restart_needed = 1'b0;
    while (cells_sent - first < budget) begin
      shape = $urandom_range(19);
      if (shape < 17) begin
        rows = $urandom_range(4, 1);
        cols = $urandom_range(5, 1);
      end else if (shape < 19) begin
        rows = $urandom_range(12, 5);
        cols = $urandom_range(3, 1);
      end else begin
        rows = $urandom_range(2, 1);
        cols = $urandom_range(12, 6);
      end
      rows_raw = (rows == 1 && $urandom_range(1)) ? 7'd0 : CNT_W'(rows);
      cols_raw = (cols == 1 && $urandom_range(1)) ? 7'd0 : CNT_W'(cols);
      if (restart_needed || rows_raw != grid_rows_reg)
        write_register(REG_ROW_COUNT, rows_raw);
      if (cols_raw != grid_cols_reg) write_register(REG_COL_COUNT, cols_raw);
      restart_needed = 1'b0;

      case ($urandom_range(9))
        0, 1:    fill = FILL_TINY;   // many ties
        2:       fill = FILL_MAX;
        3, 4:    fill = FILL_EDGES;
        default: fill = FILL_ANY;
      endcase
      cells = rows * cols;
      if (cells > 1 && $urandom_range(9) == 0) begin
        cells = $urandom_range(cells - 1, 1);
        restart_needed = 1'b1;
        broken_grids++;
      end
      for (int i = 0; i < cells; i++) send_cell(pick_value(fill));
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_cells();
    test_single_column();
    test_shared_moves();
    test_restart_midgrid();
    test_size_limits();
    test_random_grids(70);

    send_idle_pct = 64;
    recv_idle_pct = 37;
    test_random_grids(70);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_grids(70);

    // drain, then give a stray result time to show up
    await_idle();
    repeat (sweep_cycles()) @(posedge clk);
    if (expected_totals.size() != 0)
      note_failure($sformatf("%0d predicted totals never arrived",
                             expected_totals.size()));

    $display("Sent %0d cells, checked %0d grid totals, %0d register writes,",
             cells_sent, totals_seen, cfg_writes);
    $display("%0d grids cut short; idle mixes 37/64, 64/37 and none; %0d failures",
             broken_grids, fail_count);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("Timeout: %0d totals still pending", expected_totals.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### two_walker_grid_max_collect_unit.f
+incdir+rtl
rtl/twgmc_pkg.sv
rtl/twgmc_row_buf.sv
rtl/twgmc_score_ram.sv
rtl/twgmc_seq.sv
rtl/two_walker_grid_max_collect_unit.sv
tb/tb.sv
